### sv/svbd_pkg.sv
// Shared types, widths and helpers for the signed varint byte decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package svbd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned LenW     = 3;
  localparam int unsigned CountW   = 3;
  localparam int unsigned OutDataW = 40;

  // Width selector taken from bits [5:4] of a multi-byte lead byte.
  typedef enum logic [1:0] {
    SEL_12 = 2'd0,
    SEL_20 = 2'd1,
    SEL_28 = 2'd2,
    SEL_32 = 2'd3
  } svbd_sel_e;

  typedef struct packed {
    logic [LenW-1:0]          encoded_length;
    logic signed [ValueW-1:0] value;
  } svbd_result_t;

  // Sign-extend the gathered bits according to the selected width.
  function automatic logic [ValueW-1:0] svbd_sign_extend(input logic [ValueW-1:0] v,
                                                         input svbd_sel_e sel);
    logic [ValueW-1:0] r;
    case (sel)
      SEL_12:  r = {{(ValueW-12){v[11]}}, v[11:0]};
      SEL_20:  r = {{(ValueW-20){v[19]}}, v[19:0]};
      SEL_28:  r = {{(ValueW-28){v[27]}}, v[27:0]};
      SEL_32:  r = v;
      default: r = v;
    endcase
    return r;
  endfunction

endpackage

### sv/svbd_step.sv
// Decode state and per-byte update logic for the signed varint byte decoder.
// Depends on svbd_pkg.
`timescale 1ns / 1ps

module svbd_step
  import svbd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,   // consume byte_i this cycle
  input  logic [ByteW-1:0]  byte_i,
  output logic              emit_o,   // byte_i completes a value
  output svbd_result_t      result_o
);

  logic [CountW-1:0] bytes_left_q, bytes_left_d;
  logic [ValueW-1:0] acc_q, acc_d;
  svbd_sel_e         sel_q, sel_d;
  logic [LenW-1:0]   len_q, len_d;

  logic [ValueW-1:0] acc_shift;
  logic [CountW-1:0] left_dec;
  logic [LenW-1:0]   len_inc;

  assign acc_shift = {acc_q[ValueW-ByteW-1:0], byte_i};
  assign left_dec  = bytes_left_q - CountW'(1);
  assign len_inc   = len_q + LenW'(1);

  always_comb begin
    bytes_left_d = bytes_left_q;
    acc_d        = acc_q;
    sel_d        = sel_q;
    len_d        = len_q;
    emit_o       = 1'b0;
    result_o     = '0;
    if (step_i) begin
      if (bytes_left_q == '0) begin
        if (!byte_i[7]) begin
          // short positive form
          emit_o                  = 1'b1;
          result_o.value          = {{(ValueW-ByteW){1'b0}}, byte_i};
          result_o.encoded_length = LenW'(1);
        end else if (byte_i[6]) begin
          // short negative form
          emit_o                  = 1'b1;
          result_o.value          = {{(ValueW-ByteW){1'b1}}, byte_i};
          result_o.encoded_length = LenW'(1);
        end else begin
          // multi-byte lead: latch width, seed with nibble unless 32-bit form
          sel_d        = svbd_sel_e'(byte_i[5:4]);
          acc_d        = (svbd_sel_e'(byte_i[5:4]) == SEL_32) ? '0
                         : {{(ValueW-4){1'b0}}, byte_i[3:0]};
          bytes_left_d = CountW'(byte_i[5:4]) + CountW'(1);
          len_d        = LenW'(1);
        end
      end else begin
        bytes_left_d = left_dec;
        if (left_dec == '0) begin
          emit_o                  = 1'b1;
          result_o.value          = svbd_sign_extend(acc_shift, sel_q);
          result_o.encoded_length = len_inc;
          acc_d                   = '0;
          len_d                   = '0;
        end else begin
          acc_d = acc_shift;
          len_d = len_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      acc_q        <= '0;
      sel_q        <= SEL_12;
      len_q        <= '0;
    end else begin
      bytes_left_q <= bytes_left_d;
      acc_q        <= acc_d;
      sel_q        <= sel_d;
      len_q        <= len_d;
    end
  end

endmodule

### sv/svbd_out_buf.sv
// Result register with a skid stage for the signed varint byte decoder.
// Depends on svbd_pkg.
`timescale 1ns / 1ps

module svbd_out_buf
  import svbd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  svbd_result_t data_i,
  output logic         valid_o,
  input  logic         ready_i,
  output svbd_result_t data_o
);

  logic         out_valid_q, out_valid_d;
  logic         skid_valid_q, skid_valid_d;
  svbd_result_t out_data_q, out_data_d;
  svbd_result_t skid_data_q, skid_data_d;
  logic         take;

  assign ready_o = !skid_valid_q;
  assign take    = valid_i && !skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || ready_i) begin
      if (skid_valid_q) begin
        // drain the skid word first
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = take;
        out_data_d  = data_i;
      end
    end else if (take) begin
      // output held by the receiver: park the new word
      skid_valid_d = 1'b1;
      skid_data_d  = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

endmodule

### sv/signed_varint_byte_decoder_core.sv
// Top level of the signed varint byte decoder: input register, decode step, result buffer.
// Depends on svbd_pkg, svbd_step and svbd_out_buf.
`timescale 1ns / 1ps

// Usage
//   Slave stream: one encoded byte per word on s_axis_tdata_i[7:0].
//   Master stream: one decoded integer per word; value in tdata[31:0]
//   (two's complement) and encoded length (1..5) in tdata[34:32].
//   Lead bytes 0xxxxxxx and 11xxxxxx give a result on their own; lead
//   bytes 10ssnnnn start a 2- to 5-byte value, and only the byte that
//   completes it produces a result word. Other bytes produce nothing.
// Throughput and pipeline
//   One byte per cycle sustained while the result buffer is not full.
//   A byte is held in the input register and decoded into the result
//   register (or the skid register while the output is held) before
//   it shows on the master side. The rate is set by the single decode
//   step between the input register and the result register.
// Reset
//   rst_ni clears the decode state (awaiting a lead byte) and empties
//   the input register and the result buffer.
// Stalls
//   When the receiver holds tready low, one more result is parked in a
//   skid register; after that the input register holds and
//   s_axis_tready_o drops until the receiver takes a word.

module signed_varint_byte_decoder_core
  import svbd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ByteW-1:0]    s_axis_tdata_i,   // [7:0] in_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // [31:0] value, [34:32] encoded_length
);

  logic             in_valid_q, in_valid_d;
  logic [ByteW-1:0] in_byte_q, in_byte_d;
  logic             buf_ready;
  logic             advance;
  logic             emit;
  svbd_result_t     step_res;
  svbd_result_t     out_res;

  // Advance the held byte whenever the result buffer can take a word.
  assign advance         = in_valid_q && buf_ready;
  assign s_axis_tready_o = !in_valid_q || buf_ready;

  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    if (s_axis_tready_o) begin
      in_valid_d = s_axis_tvalid_i;
      in_byte_d  = s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
  end

  svbd_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (in_byte_q),
    .emit_o   (emit),
    .result_o (step_res)
  );

  svbd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (emit),
    .ready_o (buf_ready),
    .data_i  (step_res),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (out_res)
  );

  assign m_axis_tdata_o = {{(OutDataW-ValueW-LenW){1'b0}},
                           out_res.encoded_length, out_res.value};

endmodule
